// ===== rtl/dlfb_pkg.sv =====
// ----------------------------------------------------------------------------
// dlfb_pkg
// Shared types, constants and the CRC-16/DNP byte update for the frame builder.
// ----------------------------------------------------------------------------
package dlfb_pkg;

  localparam int unsigned BLOCK_BYTES_DEF = 16;
  localparam int unsigned MAX_PAYLOAD_DEF = 250;
  localparam int unsigned QUEUE_DEPTH     = 4;

  localparam logic [7:0]  SYNC_0       = 8'h05;
  localparam logic [7:0]  SYNC_1       = 8'h64;
  localparam logic [7:0]  LEN_OVERHEAD = 8'd5;
  localparam logic [15:0] CRC_POLY_REV = 16'hA6BC;

  localparam int unsigned HDR_CRC_LO = 8;
  localparam int unsigned HDR_CRC_HI = 9;

  // input opcodes (tuser)
  localparam logic OP_START   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_LEN     = 2'd1,
    STATUS_NOFRAME = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_HDR     = 2'd0,
    KIND_PAY     = 2'd1,
    KIND_ERR_LEN = 2'd2,
    KIND_ERR_PAY = 2'd3
  } kind_e;

  // One queued command: a header, a payload byte with optional block CRC, or an error.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;     // control code (header) or payload byte
    logic [7:0]  len;
    logic [15:0] crc;      // inverted block CRC for the trailer
    logic        trailer;
    logic        done;     // last payload byte of the frame
  } cmd_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REV;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/dnp3_link_frame_builder.sv =====
// ----------------------------------------------------------------------------
// dnp3_link_frame_builder
// DNP3 link-layer frame builder with CRC-16/DNP header and block checks.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser = opcode (0 start frame, 1 payload byte); tdata carries
//   control code, payload length and data byte. Master stream: one frame byte
//   per beat, tlast on the last byte caused by an input beat, tuser holds the
//   frame-end flag and a status code (length above limit, byte outside frame).
//   Source and destination addresses sit in APB registers at 0x0 and 0x4;
//   write them only while the block is idle.
//   A start beat expands to ten output beats (header), a payload beat to one,
//   or three when a block CRC follows; errors give one beat. While tready is
//   high the output side moves one beat per cycle, so a payload stream runs at
//   one beat per cycle apart from the header and block CRC beats. An input
//   beat passes the command queue, current-command and output registers.
//   A four-entry command queue decouples the input classifier from the byte
//   expander, so input beats keep flowing while tready is low on the output
//   until the queue fills. Reset clears the frame state, the queue and the
//   address registers; before a start beat, payload beats give error beats.
// ----------------------------------------------------------------------------
module dnp3_link_frame_builder #(
  parameter int unsigned BLOCK_BYTES = dlfb_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned MAX_PAYLOAD = dlfb_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [7:0] control_code, [15:8] payload_length,
                                     // [23:16] data_byte
  input  logic        s_axis_tuser,  // [0] opcode
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
  output logic        m_axis_tlast,  // last_of_run
  output logic [2:0]  m_axis_tuser   // [0] frame_end, [2:1] status
);

  localparam logic [2:0] ADDR_SRC = 3'h0;
  localparam logic [2:0] ADDR_DST = 3'h4;

  logic [15:0]    src_q, dst_q;
  logic           cfg_wr;
  logic           cmd_push_valid, cmd_push_ready, cmd_pop_valid, cmd_pop_ready;
  dlfb_pkg::cmd_t cmd_push, cmd_pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= '0;
      dst_q <= '0;
    end else if (cfg_wr) begin
      if (paddr == ADDR_SRC) begin
        src_q <= pwdata[15:0];
      end
      if (paddr == ADDR_DST) begin
        dst_q <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_SRC: prdata = {16'h0000, src_q};
      ADDR_DST: prdata = {16'h0000, dst_q};
      default:  prdata = '0;
    endcase
  end

  dlfb_front #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .opcode_i         (s_axis_tuser),
    .control_code_i   (s_axis_tdata[7:0]),
    .payload_length_i (s_axis_tdata[15:8]),
    .data_byte_i      (s_axis_tdata[23:16]),
    .cmd_valid_o      (cmd_push_valid),
    .cmd_ready_i      (cmd_push_ready),
    .cmd_o            (cmd_push)
  );

  dlfb_fifo #(
    .WIDTH ($bits(dlfb_pkg::cmd_t)),
    .DEPTH (dlfb_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_push_valid),
    .push_ready_o (cmd_push_ready),
    .push_data_i  (cmd_push),
    .pop_valid_o  (cmd_pop_valid),
    .pop_ready_i  (cmd_pop_ready),
    .pop_data_o   (cmd_pop)
  );

  dlfb_back u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_valid_i           (cmd_pop_valid),
    .cmd_ready_o           (cmd_pop_ready),
    .cmd_i                 (cmd_pop),
    .source_address_i      (src_q),
    .destination_address_i (dst_q),
    .out_valid_o           (m_axis_tvalid),
    .out_ready_i           (m_axis_tready),
    .out_byte_o            (m_axis_tdata),
    .last_of_run_o         (m_axis_tlast),
    .frame_end_o           (m_axis_tuser[0]),
    .status_o              (m_axis_tuser[2:1])
  );

endmodule

// ===== rtl/dlfb_fifo.sv =====
// ----------------------------------------------------------------------------
// dlfb_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module dlfb_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = dlfb_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/dlfb_front.sv =====
// ----------------------------------------------------------------------------
// dlfb_front
// Accepts input beats, tracks frame state and the running block CRC, and
// turns each beat into one command for the back part.
// ----------------------------------------------------------------------------
module dlfb_front #(
  parameter int unsigned BLOCK_BYTES = dlfb_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned MAX_PAYLOAD = dlfb_pkg::MAX_PAYLOAD_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            opcode_i,
  input  logic [7:0]      control_code_i,
  input  logic [7:0]      payload_length_i,
  input  logic [7:0]      data_byte_i,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output dlfb_pkg::cmd_t  cmd_o
);

  localparam int unsigned FillW = $clog2(BLOCK_BYTES + 1);

  logic             open_q, open_d;
  logic [7:0]       remain_q, remain_d;
  logic [FillW-1:0] fill_q, fill_d, fill_inc;
  logic [15:0]      crc_q, crc_d, crc_next;
  logic             accept, done, trailer;

  assign in_ready_o  = cmd_ready_i;
  assign accept      = in_valid_i && cmd_ready_i;
  assign cmd_valid_o = accept;

  assign crc_next = dlfb_pkg::crc_feed(crc_q, data_byte_i);
  assign fill_inc = fill_q + 1'b1;
  assign done     = (remain_q == 8'd1);
  assign trailer  = (fill_inc >= FillW'(BLOCK_BYTES)) || done;

  always_comb begin
    open_d       = open_q;
    remain_d     = remain_q;
    fill_d       = fill_q;
    crc_d        = crc_q;
    cmd_o        = '0;
    cmd_o.data   = data_byte_i;
    cmd_o.len    = payload_length_i;
    cmd_o.crc    = ~crc_next;
    cmd_o.kind   = dlfb_pkg::KIND_PAY;
    if (opcode_i == dlfb_pkg::OP_START) begin
      open_d   = 1'b0;
      remain_d = '0;
      fill_d   = '0;
      crc_d    = '0;
      if (payload_length_i > 8'(MAX_PAYLOAD)) begin
        cmd_o.kind = dlfb_pkg::KIND_ERR_LEN;
      end else begin
        cmd_o.kind = dlfb_pkg::KIND_HDR;
        cmd_o.data = control_code_i;
        open_d     = (payload_length_i != 8'd0);
        remain_d   = payload_length_i;
      end
    end else if (!open_q) begin
      cmd_o.kind = dlfb_pkg::KIND_ERR_PAY;
    end else begin
      cmd_o.trailer = trailer;
      cmd_o.done    = done;
      remain_d      = remain_q - 1'b1;
      if (trailer) begin
        fill_d = '0;
        crc_d  = '0;
      end else begin
        fill_d = fill_inc;
        crc_d  = crc_next;
      end
      if (done) begin
        open_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= 1'b0;
      remain_q <= '0;
      fill_q   <= '0;
      crc_q    <= '0;
    end else if (accept) begin
      open_q   <= open_d;
      remain_q <= remain_d;
      fill_q   <= fill_d;
      crc_q    <= crc_d;
    end
  end

endmodule

// ===== rtl/dlfb_back.sv =====
// ----------------------------------------------------------------------------
// dlfb_back
// Expands queued commands into output bytes, one beat per cycle while the
// output is ready, computing the header CRC as the header bytes go out.
// ----------------------------------------------------------------------------
module dlfb_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  dlfb_pkg::cmd_t  cmd_i,
  input  logic [15:0]     source_address_i,
  input  logic [15:0]     destination_address_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            last_of_run_o,
  output logic            frame_end_o,
  output logic [1:0]      status_o
);

  dlfb_pkg::cmd_t cur_q;
  logic           cur_valid_q;
  logic [3:0]     idx_q;
  logic [15:0]    hcrc_q;
  logic [15:0]    hcrc_inv;

  logic           emit, load;
  logic [7:0]     byte_c;
  logic           last_c, fend_c;
  dlfb_pkg::status_e status_c;

  logic           m_valid_q, m_last_q, m_fend_q;
  logic [7:0]     m_byte_q;
  logic [1:0]     m_status_q;

  assign hcrc_inv = ~hcrc_q;

  always_comb begin
    byte_c   = '0;
    last_c   = 1'b1;
    fend_c   = 1'b0;
    status_c = dlfb_pkg::STATUS_OK;
    unique case (cur_q.kind)
      dlfb_pkg::KIND_HDR: begin
        last_c = (idx_q == 4'(dlfb_pkg::HDR_CRC_HI));
        fend_c = last_c && (cur_q.len == 8'd0);
        case (idx_q)
          4'd0:    byte_c = dlfb_pkg::SYNC_0;
          4'd1:    byte_c = dlfb_pkg::SYNC_1;
          4'd2:    byte_c = cur_q.len + dlfb_pkg::LEN_OVERHEAD;
          4'd3:    byte_c = cur_q.data;
          4'd4:    byte_c = destination_address_i[7:0];
          4'd5:    byte_c = destination_address_i[15:8];
          4'd6:    byte_c = source_address_i[7:0];
          4'd7:    byte_c = source_address_i[15:8];
          4'd8:    byte_c = hcrc_inv[7:0];
          default: byte_c = hcrc_inv[15:8];
        endcase
      end
      dlfb_pkg::KIND_PAY: begin
        last_c = cur_q.trailer ? (idx_q == 4'd2) : 1'b1;
        fend_c = cur_q.done && (idx_q == 4'd2);
        case (idx_q)
          4'd0:    byte_c = cur_q.data;
          4'd1:    byte_c = cur_q.crc[7:0];
          default: byte_c = cur_q.crc[15:8];
        endcase
      end
      dlfb_pkg::KIND_ERR_LEN: status_c = dlfb_pkg::STATUS_LEN;
      dlfb_pkg::KIND_ERR_PAY: status_c = dlfb_pkg::STATUS_NOFRAME;
    endcase
  end

  assign emit        = cur_valid_q && (!m_valid_q || out_ready_i);
  assign load        = !cur_valid_q || (emit && last_c);
  assign cmd_ready_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      hcrc_q      <= '0;
    end else if (load) begin
      cur_valid_q <= cmd_valid_i;
      idx_q       <= '0;
      hcrc_q      <= '0;
    end else if (emit) begin
      idx_q <= idx_q + 1'b1;
      if (idx_q < 4'(dlfb_pkg::HDR_CRC_LO)) begin
        hcrc_q <= dlfb_pkg::crc_feed(hcrc_q, byte_c);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit) begin
      m_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_byte_q   <= byte_c;
      m_last_q   <= last_c;
      m_fend_q   <= fend_c;
      m_status_q <= status_c;
    end
  end

  assign out_valid_o   = m_valid_q;
  assign out_byte_o    = m_byte_q;
  assign last_of_run_o = m_last_q;
  assign frame_end_o   = m_fend_q;
  assign status_o      = m_status_q;

endmodule
